@@ rtl/dadw_pkg.sv @@
// Shared types, constants and calendar functions for the date walker.
package dadw_pkg;

    localparam logic [13:0] YEAR_MAX   = 14'd16383;
    localparam logic [13:0] YEAR_CYCLE = 14'd400;
    localparam logic [8:0]  YMOD_LAST  = 9'd399;
    localparam logic [3:0]  MONTH_JAN  = 4'd1;
    localparam logic [3:0]  MONTH_FEB  = 4'd2;
    localparam logic [3:0]  MONTH_DEC  = 4'd12;
    localparam logic [4:0]  DAY_LAST_DEC = 5'd31;
    localparam logic [2:0]  WDAY_LAST  = 3'd7;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
    } t_date;

    typedef struct packed {
        logic done;
        logic oor;
    } t_step_ctl;

    function automatic logic is_leap(input logic [1:0] ylow, input logic [8:0] ymod);
        logic century;
        century = (ymod == 9'd100) || (ymod == 9'd200) || (ymod == 9'd300);
        return (ylow == 2'd0) && !century;
    endfunction

    function automatic logic [4:0] month_len(input logic leap, input logic [3:0] month);
        logic [4:0] len;
        unique case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            MONTH_FEB:                                  len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd31;
        endcase
        return len;
    endfunction

    function automatic logic [5:0] mod7(input logic [5:0] v);
        logic [5:0] t;
        t = v;
        if (t >= 6'd56) t = t - 6'd56;
        if (t >= 6'd28) t = t - 6'd28;
        if (t >= 6'd14) t = t - 6'd14;
        if (t >= 6'd7)  t = t - 6'd7;
        return t;
    endfunction

endpackage

@@ rtl/dadw_in_if.sv @@
// Valid/ready channel carrying one start date and day offset per beat.
interface dadw_in_if #(
    parameter int OFFSET_BITS = 21
);
    logic                          valid;
    logic                          ready;
    logic        [13:0]            start_year;
    logic        [3:0]             start_month;
    logic        [4:0]             start_day;
    logic        [2:0]             start_weekday;
    logic signed [OFFSET_BITS-1:0] day_offset;

    modport source (output valid, start_year, start_month, start_day, start_weekday,
                    day_offset, input ready);
    modport sink   (input valid, start_year, start_month, start_day, start_weekday,
                    day_offset, output ready);
endinterface

@@ rtl/dadw_out_if.sv @@
// Valid/ready channel carrying one resulting date per beat.
interface dadw_out_if;
    logic        valid;
    logic        ready;
    logic [13:0] end_year;
    logic [3:0]  end_month;
    logic [4:0]  end_day;
    logic [2:0]  end_weekday;
    logic        out_of_range;

    modport source (output valid, end_year, end_month, end_day, end_weekday, out_of_range,
                    input ready);
    modport sink   (input valid, end_year, end_month, end_day, end_weekday, out_of_range,
                    output ready);
endinterface

@@ rtl/dadw_month_step.sv @@
// Month step unit: moves the date by one month or finishes the walk.
module dadw_month_step #(
    parameter int OFFSET_BITS = 21
) (
    input  dadw_pkg::t_date          i_date,
    input  logic [8:0]               i_ymod,
    input  logic [OFFSET_BITS-1:0]   i_rem,
    input  logic                     i_back,
    output dadw_pkg::t_date          o_date,
    output logic [8:0]               o_ymod,
    output logic [OFFSET_BITS-1:0]   o_rem,
    output logic [4:0]               o_delta,
    output dadw_pkg::t_step_ctl      o_ctl
);
    logic       w_leap;
    logic [4:0] w_len;
    logic [4:0] w_room;
    logic [5:0] w_take;
    logic       w_fits;

    assign w_leap = dadw_pkg::is_leap(i_date.year[1:0], i_ymod);
    assign w_len  = dadw_pkg::month_len(w_leap, i_date.month);
    assign w_room = i_back ? (i_date.day - 5'd1) : (w_len - i_date.day);
    assign w_take = i_back ? {1'b0, i_date.day} : ({1'b0, w_room} + 6'd1);
    assign w_fits = i_rem <= OFFSET_BITS'(w_room);

    always_comb begin
        o_date  = i_date;
        o_ymod  = i_ymod;
        o_rem   = i_rem;
        o_delta = w_room;
        o_ctl   = '0;
        if (w_fits) begin
            o_delta    = i_rem[4:0];
            o_rem      = '0;
            o_ctl.done = 1'b1;
            o_date.day = i_back ? (i_date.day - i_rem[4:0]) : (i_date.day + i_rem[4:0]);
        end else if (!i_back) begin
            if (i_date.month == dadw_pkg::MONTH_DEC && i_date.year == dadw_pkg::YEAR_MAX) begin
                o_date.day = w_len;
                o_ctl.done = 1'b1;
                o_ctl.oor  = 1'b1;
            end else begin
                o_delta    = w_take[4:0];
                o_rem      = i_rem - OFFSET_BITS'(w_take);
                o_date.day = 5'd1;
                if (i_date.month == dadw_pkg::MONTH_DEC) begin
                    o_date.month = dadw_pkg::MONTH_JAN;
                    o_date.year  = i_date.year + 14'd1;
                    o_ymod       = (i_ymod == dadw_pkg::YMOD_LAST) ? 9'd0 : i_ymod + 9'd1;
                end else begin
                    o_date.month = i_date.month + 4'd1;
                end
            end
        end else begin
            if (i_date.month == dadw_pkg::MONTH_JAN && i_date.year == 14'd0) begin
                o_date.day = 5'd1;
                o_ctl.done = 1'b1;
                o_ctl.oor  = 1'b1;
            end else begin
                o_delta = w_take[4:0];
                o_rem   = i_rem - OFFSET_BITS'(w_take);
                if (i_date.month == dadw_pkg::MONTH_JAN) begin
                    o_date.month = dadw_pkg::MONTH_DEC;
                    o_date.day   = dadw_pkg::DAY_LAST_DEC;
                    o_date.year  = i_date.year - 14'd1;
                    o_ymod       = (i_ymod == 9'd0) ? dadw_pkg::YMOD_LAST : i_ymod - 9'd1;
                end else begin
                    o_date.month = i_date.month - 4'd1;
                    o_date.day   = dadw_pkg::month_len(w_leap, i_date.month - 4'd1);
                end
            end
        end
    end
endmodule

@@ rtl/date_add_days_walker.sv @@
// Top level: sequencer, weekday tracking and output register of the date walker.
//
//  channel | dir | fields
//  i_in    | in  | start_year, start_month, start_day, start_weekday, day_offset
//  o_out   | out | end_year, end_month, end_day, end_weekday, out_of_range
//
// Each beat is accepted, then the start year is reduced to its year-mod-400 residue
// by repeated subtraction, then the month step unit crosses month boundaries one
// at a time until the walk finishes. i_in.ready is high only while idle.
// Reset is synchronous, active low, and clears control state only.
// The result waits in the output register; a new beat is taken meanwhile, and the
// walk holds on its last step while the previous result is still untaken.
module date_add_days_walker #(
    parameter int OFFSET_BITS = 21
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dadw_in_if.sink     i_in,
    dadw_out_if.source  o_out
);
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_REDUCE = 2'd1;
    localparam logic [1:0] S_WALK   = 2'd2;

    logic [1:0]             r_state;
    dadw_pkg::t_date        r_date;
    logic [13:0]            r_ymod;
    logic [OFFSET_BITS-1:0] r_rem;
    logic                   r_back;
    logic [2:0]             r_wday;
    logic                   r_out_valid;
    dadw_pkg::t_date        r_out_date;
    logic [2:0]             r_out_wday;
    logic                   r_out_oor;

    dadw_pkg::t_date        n_date;
    logic [8:0]             n_ymod;
    logic [OFFSET_BITS-1:0] n_rem;
    logic [4:0]             w_delta;
    dadw_pkg::t_step_ctl    w_ctl;
    logic [2:0]             n_wday;
    logic [5:0]             w_wsum;
    logic [5:0]             w_wmod;
    logic [OFFSET_BITS-1:0] w_off;
    logic                   w_accept;
    logic                   w_stall;
    logic                   w_finish;
    logic [4:0]             w_len;

    dadw_month_step #(.OFFSET_BITS(OFFSET_BITS)) u_step (
        .i_date  (r_date),
        .i_ymod  (r_ymod[8:0]),
        .i_rem   (r_rem),
        .i_back  (r_back),
        .o_date  (n_date),
        .o_ymod  (n_ymod),
        .o_rem   (n_rem),
        .o_delta (w_delta),
        .o_ctl   (w_ctl)
    );

    assign w_off    = i_in.day_offset;
    assign w_accept = i_in.valid && i_in.ready;
    assign w_stall  = w_ctl.done && r_out_valid && !o_out.ready;
    assign w_finish = (r_state == S_WALK) && w_ctl.done && !w_stall;
    assign w_wsum   = r_back ? ({3'b0, r_wday} - 6'd1 + 6'd35 - {1'b0, w_delta})
                             : ({3'b0, r_wday} - 6'd1 + {1'b0, w_delta});
    assign w_wmod   = dadw_pkg::mod7(w_wsum);
    assign n_wday   = w_wmod[2:0] + 3'd1;
    assign w_len    = dadw_pkg::month_len(dadw_pkg::is_leap(r_date.year[1:0], r_ymod[8:0]),
                                          r_date.month);

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.end_year     = r_out_date.year;
    assign o_out.end_month    = r_out_date.month;
    assign o_out.end_day      = r_out_date.day;
    assign o_out.end_weekday  = r_out_wday;
    assign o_out.out_of_range = r_out_oor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= w_finish || (r_out_valid && !o_out.ready);
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) r_state <= S_REDUCE;
                end
                S_REDUCE: begin
                    if (r_ymod < dadw_pkg::YEAR_CYCLE) r_state <= S_WALK;
                end
                S_WALK: begin
                    if (w_finish) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_date.year <= i_in.start_year;
            priority if (i_in.start_month == 4'd0) begin
                r_date.month <= dadw_pkg::MONTH_JAN;
            end else if (i_in.start_month > dadw_pkg::MONTH_DEC) begin
                r_date.month <= dadw_pkg::MONTH_DEC;
            end else begin
                r_date.month <= i_in.start_month;
            end
            r_date.day <= (i_in.start_day == 5'd0) ? 5'd1 : i_in.start_day;
            r_wday     <= (i_in.start_weekday == 3'd0) ? dadw_pkg::WDAY_LAST
                                                       : i_in.start_weekday;
            r_ymod     <= i_in.start_year;
            r_back     <= w_off[OFFSET_BITS-1];
            r_rem      <= w_off[OFFSET_BITS-1] ? (~w_off + OFFSET_BITS'(1)) : w_off;
        end else if (r_state == S_REDUCE) begin
            if (r_ymod >= dadw_pkg::YEAR_CYCLE) begin
                r_ymod <= r_ymod - dadw_pkg::YEAR_CYCLE;
            end else if (r_date.day > w_len) begin
                r_date.day <= w_len;
            end
        end else if (r_state == S_WALK && !w_stall) begin
            r_date <= n_date;
            r_ymod <= {5'b0, n_ymod};
            r_rem  <= n_rem;
            r_wday <= n_wday;
            if (w_ctl.done) begin
                r_out_date <= n_date;
                r_out_wday <= n_wday;
                r_out_oor  <= w_ctl.oor;
            end
        end
    end

`ifndef SYNTHESIS
    a_accept_reduce: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_REDUCE))
        else $error("accepted beat did not start year reduction");
    a_rem_falls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |=> (r_rem <= $past(r_rem)))
        else $error("remaining day count grew during walk");
    a_ymod_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_ymod < dadw_pkg::YEAR_CYCLE))
        else $error("year residue out of range during walk");
    a_wday_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_wday != 3'd0))
        else $error("weekday zero during walk");
    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK && w_ctl.done && !w_stall) |=> r_out_valid)
        else $error("finished walk did not present a result");
`endif
endmodule
